>>> src/char_lcd_4bit_command_sequencer_defines.svh
// Assertion macros shared by the char LCD sequencer checker.
// No dependencies; include by bare file name.
`ifndef CHAR_LCD_4BIT_COMMAND_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_4BIT_COMMAND_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CLCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clcd assertion failed");

// Next-cycle implication, disabled during reset.
`define CLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clcd assertion failed");

`endif

>>> src/clcd_pkg.sv
// Types, constants and microcode ROM of the char LCD command sequencer.
// No dependencies.
package clcd_pkg;

  localparam int unsigned PC_W       = 6;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned LINE_W     = 3;
  localparam int unsigned COL_W      = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'b1;

  localparam logic [LINE_W-1:0] LINE_COUNT_RST   = 3'd2;
  localparam logic [COL_W-1:0]  COLUMN_COUNT_RST = 6'd16;

  localparam logic [7:0]  GOTO_BASE      = 8'h80;
  localparam logic [7:0]  GOTO_BASE_ROW1 = 8'hC0;
  localparam logic [7:0]  ASCII_ZERO     = 8'h30;
  localparam logic [14:0] DLY_POWER_UP   = 15'd30000;
  localparam logic [14:0] DLY_WAKE_2     = 15'd3000;
  localparam logic [14:0] DLY_WAKE_3     = 15'd100;
  localparam logic [13:0] DLY_CLEAR      = 14'd12500;

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_CLEAR = 3'd1,
    OP_GOTO  = 3'd2,
    OP_CHAR  = 3'd3,
    OP_DEC   = 3'd4,
    OP_HEX   = 3'd5,
    OP_INT   = 3'd6,
    OP_SHIFT = 3'd7
  } op_e;

  // Where a nibble comes from.
  typedef enum logic [3:0] {
    SRC_CONST = 4'd0,
    SRC_GOTO  = 4'd1,
    SRC_VALUE = 4'd2,
    SRC_DEC_H = 4'd3,
    SRC_DEC_T = 4'd4,
    SRC_DEC_U = 4'd5,
    SRC_HEX_H = 4'd6,
    SRC_HEX_L = 4'd7,
    SRC_INT_T = 4'd8,
    SRC_INT_U = 4'd9
  } src_e;

  typedef enum logic [1:0] {
    COND_NONE     = 2'd0,
    COND_GOTO_BAD = 2'd1,
    COND_CNT_ZERO = 2'd2,
    COND_CNT_MORE = 2'd3
  } cond_e;

  typedef enum logic [1:0] {
    DLYB_NONE = 2'd0,
    DLYB_30K  = 2'd1,
    DLYB_3K   = 2'd2,
    DLYB_100  = 2'd3
  } dlyb_e;

  typedef struct packed {
    logic            emit;
    src_e            src;
    logic            lo;
    logic [3:0]      nib;
    logic            rs;
    logic            pwr;
    dlyb_e           dly_b;
    logic            dly_a_long;
    logic            poll;
    cond_e           cond;
    logic            fin;
    logic [PC_W-1:0] tgt;
  } uword_t;

  // Program entry points and shared stop word.
  localparam logic [PC_W-1:0] PC_INIT  = 6'd0;
  localparam logic [PC_W-1:0] PC_CLEAR = 6'd14;
  localparam logic [PC_W-1:0] PC_GOTO  = 6'd16;
  localparam logic [PC_W-1:0] PC_CHAR  = 6'd19;
  localparam logic [PC_W-1:0] PC_DEC   = 6'd21;
  localparam logic [PC_W-1:0] PC_HEX   = 6'd27;
  localparam logic [PC_W-1:0] PC_HEXC  = 6'd30;
  localparam logic [PC_W-1:0] PC_INT   = 6'd34;
  localparam logic [PC_W-1:0] PC_INTC  = 6'd37;
  localparam logic [PC_W-1:0] PC_SHIFT = 6'd41;
  localparam logic [PC_W-1:0] PC_SHLP  = 6'd42;
  localparam logic [PC_W-1:0] PC_STOP  = 6'd44;

  function automatic uword_t uw_const(logic [3:0] nib, logic poll, logic fin);
    uword_t w;
    w      = '0;
    w.emit = 1'b1;
    w.src  = SRC_CONST;
    w.nib  = nib;
    w.poll = poll;
    w.fin  = fin;
    return w;
  endfunction

  function automatic uword_t uw_byte(src_e src, logic lo, logic rs, logic fin);
    uword_t w;
    w      = '0;
    w.emit = 1'b1;
    w.src  = src;
    w.lo   = lo;
    w.rs   = rs;
    w.poll = lo;   // every byte polls after its low nibble
    w.fin  = fin;
    return w;
  endfunction

  function automatic uword_t uw_jump(cond_e cond, logic [PC_W-1:0] tgt, logic fin);
    uword_t w;
    w      = '0;
    w.cond = cond;
    w.tgt  = tgt;
    w.fin  = fin;
    return w;
  endfunction

  function automatic logic [PC_W-1:0] entry_pc(op_e op);
    logic [PC_W-1:0] pc;
    unique case (op)
      OP_INIT:  pc = PC_INIT;
      OP_CLEAR: pc = PC_CLEAR;
      OP_GOTO:  pc = PC_GOTO;
      OP_CHAR:  pc = PC_CHAR;
      OP_DEC:   pc = PC_DEC;
      OP_HEX:   pc = PC_HEX;
      OP_INT:   pc = PC_INT;
      OP_SHIFT: pc = PC_SHIFT;
      default:  pc = PC_STOP;
    endcase
    return pc;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? ASCII_ZERO + 8'(n) : 8'h37 + 8'(n);
  endfunction

  // Microcode ROM.
  function automatic uword_t urom(logic [PC_W-1:0] pc);
    uword_t w;
    w = uw_jump(COND_NONE, PC_STOP, 1'b1);
    unique case (pc)
      // init: wake-up nibbles, then function set, display, clear, entry mode
      6'd0:  begin w = uw_const(4'h3, 1'b0, 1'b0); w.pwr = 1'b1; w.dly_b = DLYB_30K; end
      6'd1:  begin w = uw_const(4'h3, 1'b0, 1'b0); w.dly_b = DLYB_3K; end
      6'd2:  begin w = uw_const(4'h3, 1'b0, 1'b0); w.dly_b = DLYB_100; end
      6'd3:  begin w = uw_const(4'h2, 1'b1, 1'b0); w.dly_b = DLYB_100; end
      6'd4:  w = uw_const(4'h2, 1'b0, 1'b0);
      6'd5:  w = uw_const(4'h8, 1'b1, 1'b0);
      6'd6:  w = uw_const(4'h0, 1'b0, 1'b0);
      6'd7:  w = uw_const(4'h8, 1'b1, 1'b0);
      6'd8:  w = uw_const(4'h0, 1'b0, 1'b0);
      6'd9:  w = uw_const(4'hC, 1'b1, 1'b0);
      6'd10: w = uw_const(4'h0, 1'b0, 1'b0);
      6'd11: w = uw_const(4'h1, 1'b1, 1'b0);
      6'd12: w = uw_const(4'h0, 1'b0, 1'b0);
      6'd13: w = uw_const(4'h6, 1'b1, 1'b1);
      // clear
      6'd14: w = uw_const(4'h0, 1'b0, 1'b0);
      6'd15: begin w = uw_const(4'h1, 1'b1, 1'b1); w.dly_a_long = 1'b1; end
      // goto
      6'd16: w = uw_jump(COND_GOTO_BAD, PC_STOP, 1'b0);
      6'd17: w = uw_byte(SRC_GOTO, 1'b0, 1'b0, 1'b0);
      6'd18: w = uw_byte(SRC_GOTO, 1'b1, 1'b0, 1'b1);
      // char
      6'd19: w = uw_byte(SRC_VALUE, 1'b0, 1'b1, 1'b0);
      6'd20: w = uw_byte(SRC_VALUE, 1'b1, 1'b1, 1'b1);
      // decimal byte
      6'd21: w = uw_byte(SRC_DEC_H, 1'b0, 1'b1, 1'b0);
      6'd22: w = uw_byte(SRC_DEC_H, 1'b1, 1'b1, 1'b0);
      6'd23: w = uw_byte(SRC_DEC_T, 1'b0, 1'b1, 1'b0);
      6'd24: w = uw_byte(SRC_DEC_T, 1'b1, 1'b1, 1'b0);
      6'd25: w = uw_byte(SRC_DEC_U, 1'b0, 1'b1, 1'b0);
      6'd26: w = uw_byte(SRC_DEC_U, 1'b1, 1'b1, 1'b1);
      // hex at position
      6'd27: w = uw_jump(COND_GOTO_BAD, PC_HEXC, 1'b0);
      6'd28: w = uw_byte(SRC_GOTO, 1'b0, 1'b0, 1'b0);
      6'd29: w = uw_byte(SRC_GOTO, 1'b1, 1'b0, 1'b0);
      6'd30: w = uw_byte(SRC_HEX_H, 1'b0, 1'b1, 1'b0);
      6'd31: w = uw_byte(SRC_HEX_H, 1'b1, 1'b1, 1'b0);
      6'd32: w = uw_byte(SRC_HEX_L, 1'b0, 1'b1, 1'b0);
      6'd33: w = uw_byte(SRC_HEX_L, 1'b1, 1'b1, 1'b1);
      // int at position
      6'd34: w = uw_jump(COND_GOTO_BAD, PC_INTC, 1'b0);
      6'd35: w = uw_byte(SRC_GOTO, 1'b0, 1'b0, 1'b0);
      6'd36: w = uw_byte(SRC_GOTO, 1'b1, 1'b0, 1'b0);
      6'd37: w = uw_byte(SRC_INT_T, 1'b0, 1'b1, 1'b0);
      6'd38: w = uw_byte(SRC_INT_T, 1'b1, 1'b1, 1'b0);
      6'd39: w = uw_byte(SRC_INT_U, 1'b0, 1'b1, 1'b0);
      6'd40: w = uw_byte(SRC_INT_U, 1'b1, 1'b1, 1'b1);
      // shift left: 0x18 repeated, no poll
      6'd41: w = uw_jump(COND_CNT_ZERO, PC_STOP, 1'b0);
      6'd42: w = uw_const(4'h1, 1'b0, 1'b0);
      6'd43: begin
        w = uw_const(4'h8, 1'b0, 1'b1);
        w.cond = COND_CNT_MORE;
        w.tgt  = PC_SHLP;
      end
      default: w = uw_jump(COND_NONE, PC_STOP, 1'b1);
    endcase
    return w;
  endfunction

endpackage

>>> src/char_lcd_4bit_command_sequencer.sv
// Char LCD 4-bit command sequencer, top level.
// Depends on clcd_pkg (types, constants, microcode ROM).
//
// Usage:
// - Slave stream (s_axis_*) takes one display command per beat. A command
//   is taken only while the sequencer is idle; tready drops for its run.
// - Master stream (m_axis_*) gives one bus write (nibble) per beat; tlast
//   marks the final write of a command, tuser is the register select.
// - cfg_* writes line_count (index 0) and column_count (index 1) for the
//   goto range check; write only while idle.
// Timing:
// - The command beat loads the step counter; the first write word then
//   fills the output register. Goto, hex, int and shift do a range or count
//   check first. After that one nibble per cycle while tready is high.
// - A command runs one microword per write plus any check or stop word:
//   init writes 14 nibbles, clear and char 2, decimal 6, a shift of n 2n,
//   and a zero shift or a rejected goto none. The pace is set by the microcode
//   step counter, one word per cycle while the output is not stalled.
// - A new command is taken the cycle after the last write leaves the
//   sequencer, even while that write still waits in the output register.
// Reset: registers return to 2 lines and 16 columns, sequencer idle,
//   no output beat pending.
// Stall: when the receiver holds tready low and a beat is pending, the
//   sequencer freezes on its current microword and the beat stays unchanged.
module char_lcd_4bit_command_sequencer #(
  parameter int unsigned SHIFT_MAX = 31
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [clcd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [clcd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [2:0] opcode, [10:3] value, [18:11] column, [26:19] row, [31:27] shift_count
  input  logic [31:0]                         s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [3:0] nibble, [4] power_on, [19:5] delay_before, [33:20] delay_after,
  // [34] poll_busy_after, [39:35] zero
  output logic [39:0]                         m_axis_tdata_o,
  // [0] reg_select
  output logic                                m_axis_tuser_o,
  output logic                                m_axis_tlast_o
);
  import clcd_pkg::*;

  localparam logic [SHIFT_W-1:0] SHIFT_LIM = SHIFT_W'(SHIFT_MAX);

  // command fields
  logic [2:0]         in_opcode;
  logic [7:0]         in_value, in_column, in_row;
  logic [SHIFT_W-1:0] in_shift;
  assign in_opcode = s_axis_tdata_i[2:0];
  assign in_value  = s_axis_tdata_i[10:3];
  assign in_column = s_axis_tdata_i[18:11];
  assign in_row    = s_axis_tdata_i[26:19];
  assign in_shift  = s_axis_tdata_i[31:27];

  logic [LINE_W-1:0]  line_count_q;
  logic [COL_W-1:0]   column_count_q;
  logic               busy_q, busy_d;
  logic [PC_W-1:0]    pc_q, pc_d;
  logic [SHIFT_W-1:0] cnt_q, cnt_d;
  logic               m_valid_q, m_valid_d;

  logic [7:0] value_q, column_q, row_q;
  logic [4:0] t10_q;    // value / 10
  logic [1:0] hund_q;   // value / 100

  logic [39:0] m_data_q, m_data_d;
  logic        m_user_q, m_user_d, m_last_q, m_last_d;

  logic accept, adv, goto_ok, cond_hit;
  uword_t w;

  assign s_axis_tready_o = !busy_q;
  assign accept          = s_axis_tvalid_i && !busy_q;
  assign adv             = busy_q && (!m_valid_q || m_axis_tready_i);
  assign w               = urom(pc_q);

  // digit split by reciprocal multiply, exact over 0..255
  logic [15:0] prod10;
  logic [13:0] prod100;
  assign prod10  = 16'(in_value) * 16'd205;
  assign prod100 = 14'(in_value) * 14'd41;

  logic [7:0] units_w;
  logic [3:0] units, dec_t;
  assign units_w = value_q - (8'({t10_q, 3'b000}) + 8'({t10_q, 1'b0}));
  assign units   = units_w[3:0];

  always_comb begin
    if (t10_q >= 5'd20) begin
      dec_t = 4'(t10_q - 5'd20);
    end else if (t10_q >= 5'd10) begin
      dec_t = 4'(t10_q - 5'd10);
    end else begin
      dec_t = t10_q[3:0];
    end
  end

  assign goto_ok = (row_q < 8'(line_count_q)) && (column_q < 8'(column_count_q));

  always_comb begin
    case (w.cond)
      COND_GOTO_BAD: cond_hit = !goto_ok;
      COND_CNT_ZERO: cond_hit = (cnt_q == '0);
      COND_CNT_MORE: cond_hit = (cnt_q > 5'd1);
      default:       cond_hit = 1'b0;
    endcase
  end

  // byte source for the current microword
  logic [7:0] src_byte;
  logic [3:0] nib;
  always_comb begin
    case (w.src)
      SRC_GOTO:  src_byte = ((row_q == 8'd1) ? GOTO_BASE_ROW1 : GOTO_BASE) | column_q;
      SRC_VALUE: src_byte = value_q;
      SRC_DEC_H: src_byte = ASCII_ZERO | 8'(hund_q);
      SRC_DEC_T: src_byte = ASCII_ZERO | 8'(dec_t);
      SRC_DEC_U: src_byte = ASCII_ZERO | 8'(units);
      SRC_HEX_H: src_byte = hex_char(value_q[7:4]);
      SRC_HEX_L: src_byte = hex_char(value_q[3:0]);
      SRC_INT_T: src_byte = ASCII_ZERO + 8'(t10_q);   // no clamp: can pass '9'
      SRC_INT_U: src_byte = ASCII_ZERO | 8'(units);
      default:   src_byte = {w.nib, w.nib};
    endcase
    nib = w.lo ? src_byte[3:0] : src_byte[7:4];
    if (w.src == SRC_CONST) begin
      nib = w.nib;
    end
  end

  logic [14:0] dly_b;
  always_comb begin
    case (w.dly_b)
      DLYB_30K: dly_b = DLY_POWER_UP;
      DLYB_3K:  dly_b = DLY_WAKE_2;
      DLYB_100: dly_b = DLY_WAKE_3;
      default:  dly_b = '0;
    endcase
  end

  // sequencer next state
  always_comb begin
    busy_d    = busy_q;
    pc_d      = pc_q;
    cnt_d     = cnt_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    m_last_d  = m_last_q;
    if (accept) begin
      busy_d = 1'b1;
      pc_d   = entry_pc(op_e'(in_opcode));
      cnt_d  = (in_shift > SHIFT_LIM) ? SHIFT_LIM : in_shift;
    end else if (adv) begin
      if (cond_hit) begin
        pc_d = w.tgt;
      end else if (w.fin) begin
        busy_d = 1'b0;
      end else begin
        pc_d = pc_q + 1'b1;
      end
      if (w.cond == COND_CNT_MORE && cond_hit) begin
        cnt_d = cnt_q - 1'b1;
      end
      if (w.emit) begin
        m_valid_d = 1'b1;
        m_data_d  = {5'd0, w.poll, (w.dly_a_long ? DLY_CLEAR : 14'd0), dly_b, w.pwr, nib};
        m_user_d  = w.rs;
        m_last_d  = w.fin && !cond_hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q   <= LINE_COUNT_RST;
      column_count_q <= COLUMN_COUNT_RST;
      busy_q         <= 1'b0;
      pc_q           <= PC_STOP;
      cnt_q          <= '0;
      m_valid_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LINE_COUNT:   line_count_q   <= cfg_data_i[LINE_W-1:0];
          CFG_COLUMN_COUNT: column_count_q <= cfg_data_i[COL_W-1:0];
          default:          ;
        endcase
      end
      busy_q    <= busy_d;
      pc_q      <= pc_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q  <= in_value;
      column_q <= in_column;
      row_q    <= in_row;
      t10_q    <= prod10[15:11];
      hund_q   <= prod100[13:12];
    end
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

>>> src/clcd_checker.sv
// Port-level checker for the char LCD sequencer, bound to the top level.
// Depends on char_lcd_4bit_command_sequencer_defines.svh.
`include "char_lcd_4bit_command_sequencer_defines.svh"

module clcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // stalled beat holds
  `CLCD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))

  // a taken command leaves the sequencer busy on the next cycle
  `CLCD_ASSERT_NEXT(a_busy_after_cmd, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

  // power-on only on the first init write, a command nibble after the long wait
  `CLCD_ASSERT_NOW(a_power_on, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[4], !m_axis_tuser_o && m_axis_tdata_o[19:5] == 15'd30000)

  // a post-write wait always ends in a busy poll
  `CLCD_ASSERT_NOW(a_wait_polls, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[33:20] != 14'd0, m_axis_tdata_o[34])

endmodule

bind char_lcd_4bit_command_sequencer clcd_checker u_clcd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
